>>> rtl/udf_pkg.sv
package udf_pkg;

    localparam int UDF_VALUE_BITS  = 32;
    localparam int UDF_MAX_FIELD   = 63;
    localparam int UDF_QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;

    // decimal digits needed for an all-ones value of the given width
    function automatic int udf_ndig(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

    // width of a character count or position within one field
    function automatic int udf_cw(input int max_field, input int ndig);
        int m;
        m = (max_field > ndig) ? max_field : ndig;
        return $clog2(m + 1);
    endfunction

    // bits of one queued field descriptor
    function automatic int udf_entry_bits(input int bits, input int max_field);
        return udf_ndig(bits) * 4 + 4 * udf_cw(max_field, udf_ndig(bits)) + 1;
    endfunction

endpackage

>>> rtl/udf_queue.sv
module udf_queue
    import udf_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = UDF_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    assign full      = (count_reg == CNTW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/udf_front.sv
module udf_front
    import udf_pkg::*;
#(
    parameter int VALUE_BITS = UDF_VALUE_BITS,
    parameter int MAX_FIELD  = UDF_MAX_FIELD,
    parameter int EW         = udf_entry_bits(UDF_VALUE_BITS, UDF_MAX_FIELD)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [5:0]            field_width,
    input  logic [6:0]            min_digits,
    input  logic                  left_justify,
    input  logic                  zero_pad,
    output logic                  push,
    input  logic                  q_full,
    output logic [EW-1:0]         push_data
);

    localparam int NDIG = udf_ndig(VALUE_BITS);
    localparam int CW   = udf_cw(MAX_FIELD, NDIG);
    localparam int NW   = $clog2(NDIG + 1);
    localparam int SW   = $clog2(VALUE_BITS);

    typedef struct packed {
        logic [NDIG*4-1:0] digits;
        logic [CW-1:0]     pre;
        logic [CW-1:0]     b0;
        logic [CW-1:0]     b1;
        logic [CW-1:0]     total;
        logic              pre_zero;
    } udf_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_PUSH = 3'b100
    } front_state_t;

    front_state_t          state_reg, state_next;
    logic [SW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] sh_reg, sh_next;
    logic [NDIG*4-1:0]     bcd_reg, bcd_next;
    logic [CW-1:0]         w_reg, w_next;
    logic [CW-1:0]         prec_reg, prec_next;
    logic                  has_prec_reg, has_prec_next;
    logic                  left_reg, left_next;
    logic                  zpad_reg, zpad_next;
    logic                  vzero_reg, vzero_next;

    logic                  accept;
    logic [6:0]            w_wide, p_wide;
    logic [NDIG*4-1:0]     bcd_adj;
    logic [NW-1:0]         nd;
    logic                  zero_case;
    logic [CW-1:0]         nd_c, lead0, body, pad, post;
    udf_entry_t            ent;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    assign w_wide = {1'b0, field_width};
    assign p_wide = {1'b0, min_digits[5:0]};

    // add-3 correction ahead of each shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                           : bcd_reg[i*4 +: 4];
        end
    end

    // digit count and field layout
    always_comb
    begin
        nd = NW'(1);
        for (int i = 1; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                nd = NW'(i + 1);
            end
        end
        zero_case = has_prec_reg && (prec_reg == '0) && vzero_reg;
        nd_c      = zero_case ? '0 : CW'(nd);
        lead0     = (has_prec_reg && (prec_reg > nd_c)) ? prec_reg - nd_c : '0;
        body      = lead0 + nd_c;
        pad       = (w_reg > body) ? w_reg - body : '0;
        post      = left_reg ? pad : '0;
        ent.digits   = bcd_reg;
        ent.pre      = left_reg ? '0 : pad;
        ent.b0       = ent.pre + lead0;
        ent.b1       = ent.b0 + nd_c;
        ent.total    = ent.b1 + post;
        ent.pre_zero = zpad_reg && !has_prec_reg;
    end

    assign push      = (state_reg == ST_PUSH) && (ent.total != '0) && !q_full;
    assign push_data = ent;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        sh_next       = sh_reg;
        bcd_next      = bcd_reg;
        w_next        = w_reg;
        prec_next     = prec_reg;
        has_prec_next = has_prec_reg;
        left_next     = left_reg;
        zpad_next     = zpad_reg;
        vzero_next    = vzero_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_CONV;
                    cnt_next      = SW'(VALUE_BITS - 1);
                    sh_next       = value;
                    bcd_next      = '0;
                    w_next        = CW'((w_wide > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : w_wide);
                    prec_next     = min_digits[6] ? '0
                                  : CW'((p_wide > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : p_wide);
                    has_prec_next = !min_digits[6];
                    left_next     = left_justify;
                    zpad_next     = zero_pad;
                    vzero_next    = (value == '0);
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[NDIG*4-2:0], sh_reg[VALUE_BITS-1]};
                sh_next  = {sh_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - SW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                // empty fields are dropped here
                if ((ent.total == '0) || !q_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        bcd_reg      <= bcd_next;
        w_reg        <= w_next;
        prec_reg     <= prec_next;
        has_prec_reg <= has_prec_next;
        left_reg     <= left_next;
        zpad_reg     <= zpad_next;
        vzero_reg    <= vzero_next;
    end

endmodule

>>> rtl/udf_back.sv
module udf_back
    import udf_pkg::*;
#(
    parameter int VALUE_BITS = UDF_VALUE_BITS,
    parameter int MAX_FIELD  = UDF_MAX_FIELD,
    parameter int EW         = udf_entry_bits(UDF_VALUE_BITS, UDF_MAX_FIELD)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_not_empty,
    output logic          pop,
    input  logic [EW-1:0] pop_data,
    output logic          char_valid,
    input  logic          char_stall,
    output logic [7:0]    out_char,
    output logic          last_char
);

    localparam int NDIG = udf_ndig(VALUE_BITS);
    localparam int CW   = udf_cw(MAX_FIELD, NDIG);
    localparam int DW   = $clog2(NDIG);

    typedef struct packed {
        logic [NDIG*4-1:0] digits;
        logic [CW-1:0]     pre;
        logic [CW-1:0]     b0;
        logic [CW-1:0]     b1;
        logic [CW-1:0]     total;
        logic              pre_zero;
    } udf_entry_t;

    udf_entry_t    ent_reg;
    logic          active_reg, active_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          valid_reg, valid_next;
    logic [7:0]    char_reg, char_next;
    logic          last_reg, last_next;

    logic          adv;
    logic          is_last;
    logic [CW-1:0] dpos;
    logic [DW-1:0] dsel;
    logic [3:0]    digit;
    logic [7:0]    ch;

    assign pop     = !active_reg && q_not_empty;
    assign adv     = active_reg && (!valid_reg || !char_stall);
    assign is_last = (idx_reg == ent_reg.total - CW'(1));

    assign dpos = ent_reg.b1 - CW'(1) - idx_reg;
    assign dsel = dpos[DW-1:0];

    always_comb
    begin
        digit = 4'd0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (dsel == DW'(i))
            begin
                digit = ent_reg.digits[i*4 +: 4];
            end
        end
    end

    always_comb
    begin
        priority if (idx_reg < ent_reg.pre)
        begin
            ch = ent_reg.pre_zero ? ASCII_ZERO : ASCII_SPACE;
        end
        else if (idx_reg < ent_reg.b0)
        begin
            ch = ASCII_ZERO;
        end
        else if (idx_reg < ent_reg.b1)
        begin
            ch = ASCII_ZERO | {4'd0, digit};
        end
        else
        begin
            ch = ASCII_SPACE;
        end
    end

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg && char_stall;
        char_next   = char_reg;
        last_next   = last_reg;
        if (pop)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (adv)
        begin
            valid_next = 1'b1;
            char_next  = ch;
            last_next  = is_last;
            idx_next   = idx_reg + CW'(1);
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= pop_data;
        end
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign char_valid = valid_reg;
    assign out_char   = char_reg;
    assign last_char  = last_reg;

endmodule

>>> rtl/unsigned_decimal_field_formatter_core.sv
// channel   direction  handshake                payload
// req       in         req_valid / req_stall    value, field_width, min_digits,
//                                               left_justify, zero_pad
// char      out        char_valid / char_stall  out_char, last_char
//
// the front converts with the one-bit-per-cycle binary to bcd shifter, then
// pushes; the back pops an entry, then sends its characters; a two-entry queue
// lets the front take the next item while the back still sends the last one
// rst_n clears all control state at once; no clearing pass
// char_stall holds the output register and, once the queue fills, the front
module unsigned_decimal_field_formatter_core
    import udf_pkg::*;
#(
    parameter int VALUE_BITS = UDF_VALUE_BITS,
    parameter int MAX_FIELD  = UDF_MAX_FIELD
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [5:0]            field_width,
    input  logic [6:0]            min_digits,
    input  logic                  left_justify,
    input  logic                  zero_pad,
    output logic                  char_valid,
    input  logic                  char_stall,
    output logic [7:0]            out_char,
    output logic                  last_char
);

    localparam int EW = udf_entry_bits(VALUE_BITS, MAX_FIELD);

    logic          push;
    logic          q_full;
    logic [EW-1:0] push_data;
    logic          pop;
    logic          q_not_empty;
    logic [EW-1:0] pop_data;

    udf_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD),
        .EW         (EW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .value        (value),
        .field_width  (field_width),
        .min_digits   (min_digits),
        .left_justify (left_justify),
        .zero_pad     (zero_pad),
        .push         (push),
        .q_full       (q_full),
        .push_data    (push_data)
    );

    udf_queue #(
        .W     (EW),
        .DEPTH (UDF_QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty)
    );

    udf_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD),
        .EW         (EW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .pop         (pop),
        .pop_data    (pop_data),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .out_char    (out_char),
        .last_char   (last_char)
    );

endmodule

>>> rtl/udf_checker.sv
module udf_checker
    import udf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_stall,
    input logic       char_valid,
    input logic       char_stall,
    input logic [7:0] out_char,
    input logic       last_char
);

    // a character held back stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid)
    else $error("char item dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> $stable(out_char) && $stable(last_char))
    else $error("char payload changed while stalled");

    // only space, or a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (out_char == ASCII_SPACE)
                    || ((out_char >= ASCII_ZERO) && (out_char <= ASCII_ZERO + 8'd9)))
    else $error("character outside the field alphabet");

    // an accepted request keeps the front busy while it converts
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("front took a request without going busy");

endmodule

bind unsigned_decimal_field_formatter_core udf_checker u_udf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .out_char   (out_char),
    .last_char  (last_char)
);
